@@ hdl/crbb_pkg.sv @@
// ----------------------------------------------------------------------------
// crbb_pkg
// Types, constants and codes shared by the clipped rgba blit/blend block.
// ----------------------------------------------------------------------------
package crbb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [PIX_W-1:0] RB_MASK   = 32'h00FF_00FF;
  localparam logic [PIX_W-1:0] G_MASK    = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] AG_MASK   = 32'hFF00_FF00;
  localparam logic [PIX_W-1:0] ONE_ALPHA = 32'h0100_0000;
  localparam logic [7:0]       ALPHA_MAX = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    REG_DEST_WIDTH    = 3'd0,
    REG_DEST_HEIGHT   = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_OFFSET_X      = 3'd4,
    REG_OFFSET_Y      = 3'd5,
    REG_BLEND_MODE    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_SKIP = 2'd0,
    OP_SRC  = 2'd1,
    OP_DST  = 2'd2,
    OP_MIX  = 2'd3
  } pix_op_t;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [DIM_W-1:0] offset_x;
    logic [DIM_W-1:0] offset_y;
    logic             blend_mode;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] dest_col;
    logic [DIM_W-1:0] dest_row;
    pix_op_t          op;
    logic             last;
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
  } job_t;

endpackage

@@ hdl/crbb_front.sv @@
// ----------------------------------------------------------------------------
// crbb_front
// Raster counters, destination mapping, clipping and pixel classification.
// ----------------------------------------------------------------------------
module crbb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crbb_pkg::cfg_t               cfg,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [crbb_pkg::PIX_W-1:0]   in_source_pixel,
  input  logic [crbb_pkg::PIX_W-1:0]   in_under_pixel,
  input  logic                         q_full,
  output logic                         q_wr,
  output crbb_pkg::job_t               q_data
);
  import crbb_pkg::*;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] sw, sh, ox, oy, x, y, col_inc, row_inc;
  logic             visible, last;
  logic [7:0]       alpha;
  pix_op_t          op;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  always_comb begin
    sw      = sat_dim(cfg.source_width);
    sh      = sat_dim(cfg.source_height);
    ox      = cfg.offset_x[DIM_W-1] ? '0 : {1'b0, cfg.offset_x[DIM_W-2:0]};
    oy      = cfg.offset_y[DIM_W-1] ? '0 : {1'b0, cfg.offset_y[DIM_W-2:0]};
    x       = ox + DIM_W'(col_r);
    y       = oy + DIM_W'(row_r);
    visible = (x < cfg.dest_width) && (y < cfg.dest_height);
    last    = (DIM_W'(col_r) == sw - DIM_W'(1)) && (DIM_W'(row_r) == sh - DIM_W'(1));
    alpha   = in_source_pixel[PIX_W-1 -: 8];
    if (!visible) op = OP_SKIP;
    else if (!cfg.blend_mode || alpha == ALPHA_MAX) op = OP_SRC;
    else if (alpha == '0) op = OP_DST;
    else op = OP_MIX;

    col_inc = DIM_W'(col_r) + DIM_W'(1);
    row_inc = DIM_W'(row_r) + DIM_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_wr) begin
      if (col_inc >= sw) begin
        col_nxt = '0;
        row_nxt = (row_inc >= sh) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  assign in_full         = q_full;
  assign q_wr            = in_push && !q_full;
  assign q_data.dest_col = x;
  assign q_data.dest_row = y;
  assign q_data.op       = op;
  assign q_data.last     = last;
  assign q_data.src      = in_source_pixel;
  assign q_data.dst      = in_under_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ hdl/crbb_queue.sv @@
// ----------------------------------------------------------------------------
// crbb_queue
// Short register queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module crbb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  crbb_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output crbb_pkg::job_t rd_data,
  output logic           empty
);
  import crbb_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + Q_AW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + (Q_AW+1)'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[Q_AW-1:0]) else $error("queue pointers disagree with count");

endmodule

@@ hdl/crbb_back.sv @@
// ----------------------------------------------------------------------------
// crbb_back
// Two-stage blend pipeline: products, then sum/mask into the result register.
// ----------------------------------------------------------------------------
module crbb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_rd,
  input  crbb_pkg::job_t               q_data,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [crbb_pkg::DIM_W-1:0]   out_dest_col,
  output logic [crbb_pkg::DIM_W-1:0]   out_dest_row,
  output logic [crbb_pkg::PIX_W-1:0]   out_pixel,
  output logic                         out_write_enable,
  output logic                         out_frame_last
);
  import crbb_pkg::*;

  logic             a_valid_r, a_valid_nxt, b_valid_r, b_valid_nxt;
  logic             a_load, b_load;
  logic [DIM_W-1:0] a_col_r, a_row_r, b_col_r, b_row_r;
  logic             a_we_r, a_last_r, a_mix_r, b_we_r, b_last_r;
  logic [PIX_W-1:0] a_pix_r, b_pix_r, pix_sel, mixed, rb_sum, ag_sum;
  logic [PIX_W-1:0] p_rbd_r, p_rbs_r, p_agd_r, p_ags_r;
  logic [PIX_W-1:0] na_w, a_w;

  assign b_load = a_valid_r && (!b_valid_r || out_pop);
  assign a_load = !q_empty && (!a_valid_r || b_load);
  assign q_rd   = a_load;

  always_comb begin
    a_valid_nxt = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_r);
    b_valid_nxt = b_load ? 1'b1 : (out_pop ? 1'b0 : b_valid_r);
    a_w  = {24'd0, q_data.src[PIX_W-1 -: 8]};
    na_w = {24'd0, ALPHA_MAX - q_data.src[PIX_W-1 -: 8]};
    unique case (q_data.op)
      OP_SKIP: pix_sel = '0;
      OP_SRC:  pix_sel = q_data.src;
      OP_DST:  pix_sel = q_data.dst;
      OP_MIX:  pix_sel = '0;
      default: pix_sel = '0;
    endcase
    rb_sum = p_rbd_r + p_rbs_r;
    ag_sum = p_agd_r + p_ags_r;
    mixed  = ((rb_sum >> 8) & RB_MASK) | (ag_sum & AG_MASK);
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_col_r  <= q_data.dest_col;
      a_row_r  <= q_data.dest_row;
      a_we_r   <= (q_data.op != OP_SKIP);
      a_last_r <= q_data.last;
      a_mix_r  <= (q_data.op == OP_MIX);
      a_pix_r  <= pix_sel;
      p_rbd_r  <= na_w * (q_data.dst & RB_MASK);
      p_rbs_r  <= a_w * (q_data.src & RB_MASK);
      p_agd_r  <= na_w * ((q_data.dst & AG_MASK) >> 8);
      p_ags_r  <= a_w * (ONE_ALPHA | ((q_data.src & G_MASK) >> 8));
    end
    if (b_load) begin
      b_col_r  <= a_col_r;
      b_row_r  <= a_row_r;
      b_we_r   <= a_we_r;
      b_last_r <= a_last_r;
      b_pix_r  <= a_mix_r ? mixed : a_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  assign out_empty        = !b_valid_r;
  assign out_dest_col     = b_col_r;
  assign out_dest_row     = b_row_r;
  assign out_pixel        = b_pix_r;
  assign out_write_enable = b_we_r;
  assign out_frame_last   = b_last_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_pop) |=> (b_valid_r && $stable(b_pix_r) && $stable(b_col_r)))
    else $error("result changed while stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && b_valid_r && !out_pop) |=> a_valid_r)
    else $error("stage a lost an item under stall");

endmodule

@@ hdl/clipped_rgba_blit_blend.sv @@
// ----------------------------------------------------------------------------
// clipped_rgba_blit_blend
// Clipped rgba blit with optional alpha blend, one source pixel per item.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_push / in_full  | in_source_pixel, in_under_pixel
//  out      | out_pop / out_empty| out_dest_col, out_dest_row, out_pixel,
//           |                    | out_write_enable, out_frame_last
//  cfg      | cfg_we             | cfg_index, cfg_data
//
//  one item per clock sustained while out_pop keeps up; a pushed item passes
//  through the queue register, the product stage and the result register
//  reset clears counters, queue and valids; config registers take their reset values
//  a stalled output backs up through the pipeline into the 4-entry queue
// ----------------------------------------------------------------------------
module clipped_rgba_blit_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [crbb_pkg::PIX_W-1:0]   in_source_pixel,
  input  logic [crbb_pkg::PIX_W-1:0]   in_under_pixel,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [crbb_pkg::DIM_W-1:0]   out_dest_col,
  output logic [crbb_pkg::DIM_W-1:0]   out_dest_row,
  output logic [crbb_pkg::PIX_W-1:0]   out_pixel,
  output logic                         out_write_enable,
  output logic                         out_frame_last,
  input  logic                         cfg_we,
  input  logic [crbb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [crbb_pkg::DIM_W-1:0]   cfg_data
);
  import crbb_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t wr_job, rd_job;
  logic q_wr, q_full, q_rd, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:    cfg_nxt.dest_width    = cfg_data;
        REG_DEST_HEIGHT:   cfg_nxt.dest_height   = cfg_data;
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = cfg_data;
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = cfg_data;
        REG_OFFSET_X:      cfg_nxt.offset_x      = cfg_data;
        REG_OFFSET_Y:      cfg_nxt.offset_y      = cfg_data;
        REG_BLEND_MODE:    cfg_nxt.blend_mode    = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width    <= DIM_W'(1);
      cfg_r.dest_height   <= DIM_W'(1);
      cfg_r.source_width  <= DIM_W'(1);
      cfg_r.source_height <= DIM_W'(1);
      cfg_r.offset_x      <= '0;
      cfg_r.offset_y      <= '0;
      cfg_r.blend_mode    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crbb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_source_pixel (in_source_pixel),
    .in_under_pixel  (in_under_pixel),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_data          (wr_job)
  );

  crbb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (wr_job),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (rd_job),
    .empty   (q_empty)
  );

  crbb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rd             (q_rd),
    .q_data           (rd_job),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_dest_col     (out_dest_col),
    .out_dest_row     (out_dest_row),
    .out_pixel        (out_pixel),
    .out_write_enable (out_write_enable),
    .out_frame_last   (out_frame_last)
  );

endmodule
